### hdl/cpf_pkg.sv
package cpf_pkg;

  localparam int unsigned SampleMax   = 65536;
  localparam int unsigned LeadLen     = 12;
  localparam int unsigned CountMax    = 131071;
  localparam int unsigned HMax        = 524288;
  localparam int unsigned ThreshReset = 519045;
  localparam int unsigned FifoDepth   = 4;
  localparam int unsigned SumW        = 38;

  typedef logic [16:0] cnt_t;
  typedef logic [LeadLen-1:0][7:0] lead_t;

  // queue entry: one nonzero bin count, or the block end descriptor
  typedef struct packed {
    logic  last;
    cnt_t  cnt;
    lead_t lead;
  } qent_t;

  typedef enum logic [1:0] {
    RSN_NONE    = 2'd0,
    RSN_EMPTY   = 2'd1,
    RSN_MAGIC   = 2'd2,
    RSN_ENTROPY = 2'd3
  } reason_e;

  localparam logic [3:0] TYPE_NONE  = 4'd0;
  localparam logic [3:0] TYPE_JPEG  = 4'd1;
  localparam logic [3:0] TYPE_PNG   = 4'd2;
  localparam logic [3:0] TYPE_GIF   = 4'd3;
  localparam logic [3:0] TYPE_WEBP  = 4'd4;
  localparam logic [3:0] TYPE_MP4   = 4'd5;
  localparam logic [3:0] TYPE_ZIP   = 4'd6;
  localparam logic [3:0] TYPE_7Z    = 4'd7;
  localparam logic [3:0] TYPE_GZIP  = 4'd8;
  localparam logic [3:0] TYPE_ZSTD  = 4'd9;
  localparam logic [3:0] TYPE_RAR   = 4'd10;
  localparam logic [3:0] TYPE_BZIP2 = 4'd11;
  localparam logic [3:0] TYPE_XZ    = 4'd12;
  localparam logic [3:0] TYPE_OGG   = 4'd13;
  localparam logic [3:0] TYPE_MP3   = 4'd14;
  localparam logic [3:0] TYPE_WOFF2 = 4'd15;

  typedef struct packed {
    logic        valid;
    logic        store;
    reason_e     reason;
    logic [3:0]  kind;
    logic [19:0] entropy;
    cnt_t        sampled;
  } res_t;

  typedef enum logic [2:0] {
    F_CLR, F_IDLE, F_FLUSH, F_RD, F_WR, F_DESC
  } front_state_e;

  typedef enum logic [2:0] {
    B_IDLE, B_BLOG, B_BMUL, B_MLOG, B_DIV, B_OUT
  } back_state_e;

endpackage

### hdl/cpf_fifo.sv
module cpf_fifo
  import cpf_pkg::*;
(
  input  logic  clk_i,
  input  logic  rst_ni,
  input  logic  push_i,
  input  qent_t data_i,
  output logic  full_o,
  input  logic  pop_i,
  output logic  empty_o,
  output qent_t data_o
);

  localparam int unsigned PtrW = $clog2(FifoDepth);

  qent_t            mem_q [FifoDepth];
  logic [PtrW-1:0]  wp_q, rp_q;
  logic [PtrW:0]    cnt_q;

  assign full_o  = (cnt_q == (PtrW+1)'(FifoDepth));
  assign empty_o = (cnt_q == '0);
  assign data_o  = mem_q[rp_q];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wp_q  <= '0;
      rp_q  <= '0;
      cnt_q <= '0;
    end else begin
      if (push_i && !full_o) wp_q <= wp_q + 1'b1;
      if (pop_i && !empty_o) rp_q <= rp_q + 1'b1;
      case ({push_i && !full_o, pop_i && !empty_o})
        2'b10:   cnt_q <= cnt_q + 1'b1;
        2'b01:   cnt_q <= cnt_q - 1'b1;
        default: cnt_q <= cnt_q;
      endcase
    end
  end

  always_ff @(posedge clk_i) begin
    if (push_i && !full_o) mem_q[wp_q] <= data_i;
  end

endmodule

### hdl/cpf_front.sv
module cpf_front
  import cpf_pkg::*;
(
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       start,
  input  logic [7:0] byte_value_i,
  input  logic       has_byte_i,
  input  logic       end_of_block_i,
  output logic       busy,
  output logic       push_o,
  output qent_t      push_data_o,
  input  logic       full_i
);

  cnt_t         hist_q [256];
  cnt_t         rdata_q;
  front_state_e state_q, state_d;
  logic [7:0]   idx_q, idx_d;
  cnt_t         count_q, count_d;
  lead_t        lead_q, lead_d;
  logic         upd_v_q, wr_v_q;
  logic [7:0]   upd_a_q, wr_a_q;
  cnt_t         wr_d_q;

  logic       accept, take_byte, stall;
  logic       mem_re, mem_we;
  logic [7:0] mem_ra, mem_wa;
  cnt_t       mem_wd, upd_val;

  assign accept    = start && (state_q == F_IDLE);
  assign take_byte = accept && has_byte_i && (count_q < 17'(SampleMax));
  assign stall     = (rdata_q != '0) && full_i;
  // bypass the write that landed at the edge of our read
  assign upd_val   = (wr_v_q && (wr_a_q == upd_a_q)) ? wr_d_q : rdata_q;

  // per-block bookkeeping
  always_comb begin
    count_d = count_q;
    lead_d  = lead_q;
    if (accept && has_byte_i) begin
      if (count_q < 17'(LeadLen)) lead_d[count_q[3:0]] = byte_value_i;
      if (count_q < 17'(CountMax)) count_d = count_q + 1'b1;
    end
    if (state_q == F_DESC && !full_i) begin
      count_d = '0;
      lead_d  = '0;
    end
  end

  // next state
  always_comb begin
    state_d = state_q;
    idx_d   = idx_q;
    case (state_q)
      F_CLR: begin
        idx_d = idx_q + 1'b1;
        if (idx_q == 8'hFF) state_d = F_IDLE;
      end
      F_IDLE: begin
        if (accept && end_of_block_i) begin
          state_d = (count_d == '0) ? F_DESC : F_FLUSH;
        end
      end
      F_FLUSH: state_d = F_RD;
      F_RD:    state_d = F_WR;
      F_WR: begin
        if (!stall) begin
          idx_d   = idx_q + 1'b1;
          state_d = (idx_q == 8'hFF) ? F_DESC : F_RD;
        end
      end
      F_DESC: begin
        if (!full_i) state_d = F_IDLE;
      end
      default: state_d = F_CLR;
    endcase
  end

  // outputs and memory controls
  always_comb begin
    busy        = (state_q != F_IDLE);
    push_o      = 1'b0;
    push_data_o = '0;
    mem_re      = take_byte || (state_q == F_RD);
    mem_ra      = (state_q == F_RD) ? idx_q : byte_value_i;
    mem_we      = 1'b0;
    mem_wa      = idx_q;
    mem_wd      = '0;
    if (upd_v_q) begin
      mem_we = 1'b1;
      mem_wa = upd_a_q;
      mem_wd = upd_val + 1'b1;
    end else if (state_q == F_CLR || (state_q == F_WR && !stall)) begin
      mem_we = 1'b1;
    end
    case (state_q)
      F_WR: begin
        push_o       = (rdata_q != '0) && !full_i;
        push_data_o.cnt = rdata_q;
      end
      F_DESC: begin
        push_o           = !full_i;
        push_data_o.last = 1'b1;
        push_data_o.cnt  = count_q;
        push_data_o.lead = lead_q;
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk_i) begin
    if (mem_we) hist_q[mem_wa] <= mem_wd;
    if (mem_re) rdata_q <= hist_q[mem_ra];
  end

  always_ff @(posedge clk_i) begin
    upd_a_q <= byte_value_i;
    wr_a_q  <= mem_wa;
    wr_d_q  <= mem_wd;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= F_CLR;
      idx_q   <= '0;
      count_q <= '0;
      lead_q  <= '0;
      upd_v_q <= 1'b0;
      wr_v_q  <= 1'b0;
    end else begin
      state_q <= state_d;
      idx_q   <= idx_d;
      count_q <= count_d;
      lead_q  <= lead_d;
      upd_v_q <= take_byte;
      wr_v_q  <= upd_v_q;
    end
  end

endmodule

### hdl/cpf_log2.sv
module cpf_log2
  import cpf_pkg::*;
(
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        start_i,
  input  cnt_t        x_i,
  output logic        done_o,
  output logic [36:0] res_o
);

  logic        busy_q, done_q;
  logic [4:0]  cnt_q, e_q, e_in;
  logic [31:0] y_q, frac_q;
  logic [63:0] prod;
  logic [32:0] t;

  // leading one position
  always_comb begin
    e_in = '0;
    for (int i = 0; i < 17; i++) begin
      if (x_i[i]) e_in = 5'(i);
    end
  end

  assign prod   = 64'(y_q) * 64'(y_q);
  assign t      = prod[63:31];
  assign done_o = done_q;
  assign res_o  = {e_q, frac_q};

  always_ff @(posedge clk_i) begin
    if (start_i) begin
      e_q    <= e_in;
      y_q    <= {15'b0, x_i} << (5'd31 - e_in);
      frac_q <= '0;
    end else if (busy_q) begin
      if (t[32]) begin
        y_q    <= t[32:1];
        frac_q <= {frac_q[30:0], 1'b1};
      end else begin
        y_q    <= t[31:0];
        frac_q <= {frac_q[30:0], 1'b0};
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      done_q <= 1'b0;
      if (start_i) begin
        busy_q <= 1'b1;
        cnt_q  <= '0;
      end else if (busy_q) begin
        cnt_q <= cnt_q + 1'b1;
        if (cnt_q == 5'd31) begin
          busy_q <= 1'b0;
          done_q <= 1'b1;
        end
      end
    end
  end

endmodule

### hdl/cpf_back.sv
module cpf_back
  import cpf_pkg::*;
(
  input  logic        clk_i,
  input  logic        rst_ni,
  input  qent_t       head_i,
  input  logic        empty_i,
  output logic        pop_o,
  input  logic [19:0] thresh_i,
  output res_t        res_o
);

  back_state_e      state_q, state_d;
  logic [SumW-1:0]  sum_q, quo_q;
  cnt_t             c_q, n_q, m_q, rem_q, m_in;
  logic [53:0]      prod_q;
  lead_t            lead_q;
  logic [20:0]      logm_q, diff;
  logic [5:0]       dcnt_q;
  res_t             res_q;
  logic             lg_start, lg_done;
  cnt_t             lg_x;
  logic [36:0]      lg_res;
  logic [17:0]      trial;
  logic             qbit;
  logic [3:0]       kind;
  logic [19:0]      h;

  function automatic logic [3:0] match_sig(input cnt_t n, input lead_t d);
    logic [3:0] r;
    r = TYPE_NONE;
    if (n < 17'd4) r = TYPE_NONE;
    else if (d[0] == 8'hFF && d[1] == 8'hD8 && d[2] == 8'hFF) r = TYPE_JPEG;
    else if (n >= 17'd8 && d[0] == 8'h89 && d[1] == 8'h50 && d[2] == 8'h4E &&
             d[3] == 8'h47 && d[4] == 8'h0D && d[5] == 8'h0A && d[6] == 8'h1A &&
             d[7] == 8'h0A) r = TYPE_PNG;
    else if (n >= 17'd6 && d[0] == 8'h47 && d[1] == 8'h49 && d[2] == 8'h46 &&
             d[3] == 8'h38) r = TYPE_GIF;
    else if (n >= 17'd12 && d[0] == 8'h52 && d[1] == 8'h49 && d[2] == 8'h46 &&
             d[3] == 8'h46 && d[8] == 8'h57 && d[9] == 8'h45 && d[10] == 8'h42 &&
             d[11] == 8'h50) r = TYPE_WEBP;
    else if (n >= 17'd12 && d[4] == 8'h66 && d[5] == 8'h74 && d[6] == 8'h79 &&
             d[7] == 8'h70) r = TYPE_MP4;
    else if (d[0] == 8'h50 && d[1] == 8'h4B &&
             ((d[2] == 8'h03 && d[3] == 8'h04) || (d[2] == 8'h01 && d[3] == 8'h02) ||
              (d[2] == 8'h05 && d[3] == 8'h06) || (d[2] == 8'h07 && d[3] == 8'h08)))
      r = TYPE_ZIP;
    else if (n >= 17'd6 && d[0] == 8'h37 && d[1] == 8'h7A && d[2] == 8'hBC &&
             d[3] == 8'hAF && d[4] == 8'h27 && d[5] == 8'h1C) r = TYPE_7Z;
    else if (d[0] == 8'h1F && d[1] == 8'h8B) r = TYPE_GZIP;
    else if (d[0] == 8'h28 && d[1] == 8'hB5 && d[2] == 8'h2F && d[3] == 8'hFD)
      r = TYPE_ZSTD;
    else if (n >= 17'd7 && d[0] == 8'h52 && d[1] == 8'h61 && d[2] == 8'h72 &&
             d[3] == 8'h21 && d[4] == 8'h1A && d[5] == 8'h07) r = TYPE_RAR;
    else if (d[0] == 8'h42 && d[1] == 8'h5A && d[2] == 8'h68) r = TYPE_BZIP2;
    else if (n >= 17'd6 && d[0] == 8'hFD && d[1] == 8'h37 && d[2] == 8'h7A &&
             d[3] == 8'h58 && d[4] == 8'h5A && d[5] == 8'h00) r = TYPE_XZ;
    else if (d[0] == 8'h4F && d[1] == 8'h67 && d[2] == 8'h67 && d[3] == 8'h53)
      r = TYPE_OGG;
    else if ((d[0] == 8'h49 && d[1] == 8'h44 && d[2] == 8'h33) ||
             (d[0] == 8'hFF && (d[1] & 8'hE0) == 8'hE0)) r = TYPE_MP3;
    else if (d[0] == 8'h77 && d[1] == 8'h4F && d[2] == 8'h46 && d[3] == 8'h32)
      r = TYPE_WOFF2;
    return r;
  endfunction

  cpf_log2 u_log2 (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .start_i (lg_start),
    .x_i     (lg_x),
    .done_o  (lg_done),
    .res_o   (lg_res)
  );

  assign m_in  = (head_i.cnt < 17'(SampleMax)) ? head_i.cnt : 17'(SampleMax);
  assign trial = {rem_q, quo_q[SumW-1]};
  assign qbit  = (trial >= {1'b0, m_q});
  assign kind  = match_sig(n_q, lead_q);
  assign diff  = logm_q - quo_q[20:0];

  always_comb begin
    if (quo_q >= SumW'(logm_q)) h = '0;
    else if (diff > 21'(HMax)) h = 20'(HMax);
    else h = diff[19:0];
  end

  // next state
  always_comb begin
    state_d = state_q;
    case (state_q)
      B_IDLE: begin
        if (!empty_i) begin
          if (!head_i.last) state_d = B_BLOG;
          else if (head_i.cnt != '0) state_d = B_MLOG;
        end
      end
      B_BLOG:  if (lg_done) state_d = B_BMUL;
      B_BMUL:  state_d = B_IDLE;
      B_MLOG:  if (lg_done) state_d = B_DIV;
      B_DIV:   if (dcnt_q == 6'(SumW - 1)) state_d = B_OUT;
      B_OUT:   state_d = B_IDLE;
      default: state_d = B_IDLE;
    endcase
  end

  // outputs
  always_comb begin
    pop_o    = (state_q == B_IDLE) && !empty_i;
    lg_start = pop_o && (!head_i.last || head_i.cnt != '0);
    lg_x     = head_i.last ? m_in : head_i.cnt;
    res_o    = res_q;
  end

  always_ff @(posedge clk_i) begin
    case (state_q)
      B_IDLE: begin
        if (!empty_i) begin
          c_q    <= head_i.cnt;
          n_q    <= head_i.cnt;
          m_q    <= m_in;
          lead_q <= head_i.lead;
        end
      end
      B_BLOG: if (lg_done) prod_q <= 54'(c_q) * 54'(lg_res);
      B_MLOG: begin
        if (lg_done) begin
          logm_q <= 21'((lg_res + 37'd32768) >> 16);
          quo_q  <= sum_q;
          rem_q  <= '0;
          dcnt_q <= '0;
        end
      end
      B_DIV: begin
        rem_q  <= qbit ? 17'(trial - {1'b0, m_q}) : trial[16:0];
        quo_q  <= {quo_q[SumW-2:0], qbit};
        dcnt_q <= dcnt_q + 1'b1;
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= B_IDLE;
      sum_q   <= '0;
      res_q   <= '0;
    end else begin
      state_q     <= state_d;
      res_q.valid <= 1'b0;
      if (state_q == B_BMUL) begin
        sum_q <= sum_q + SumW'((prod_q + 54'd32768) >> 16);
      end
      if (state_q == B_IDLE && !empty_i && head_i.last && head_i.cnt == '0) begin
        res_q <= '{valid: 1'b1, store: 1'b1, reason: RSN_EMPTY, kind: TYPE_NONE,
                   entropy: '0, sampled: '0};
      end
      if (state_q == B_OUT) begin
        sum_q         <= '0;
        res_q.valid   <= 1'b1;
        res_q.kind    <= kind;
        res_q.entropy <= h;
        res_q.sampled <= m_q;
        if (kind != TYPE_NONE) begin
          res_q.store  <= 1'b1;
          res_q.reason <= RSN_MAGIC;
        end else if (h >= thresh_i) begin
          res_q.store  <= 1'b1;
          res_q.reason <= RSN_ENTROPY;
        end else begin
          res_q.store  <= 1'b0;
          res_q.reason <= RSN_NONE;
        end
      end
    end
  end

endmodule

### hdl/compressibility_prefilter_top.sv
// Compressibility prefilter. Feed a block one byte per transfer (start high
// while busy is low); the transfer carrying end_of_block closes the block,
// with or without a byte. Bytes are taken one per cycle while a block runs.
// After the closing transfer busy stays high while the 256-bin histogram is
// swept out and cleared, and longer when the result side falls behind: each
// nonzero bin occupies the result side in the shared log2 unit (32 squaring
// steps) and the multiplier, and a 4-entry queue sits between the two. After
// the back end takes the block end, the verdict follows a log2 of the sample
// count and a 38-step divide. An empty block skips the sweep and still
// returns a verdict. Each verdict is on the result ports for one cycle
// with done_o high; the receiver cannot stall it and must take it then.
// After reset busy is high while the histogram memory is cleared. The
// threshold register may be written at any time but should only change
// between blocks.
module compressibility_prefilter_top
  import cpf_pkg::*;
(
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        start,
  output logic        busy,
  input  logic [7:0]  byte_value_i,
  input  logic        has_byte_i,
  input  logic        end_of_block_i,
  input  logic        cfg_valid_i,
  output logic        cfg_ready_o,
  input  logic [19:0] cfg_data_i,
  output logic        done_o,
  output logic        store_raw_o,
  output logic [1:0]  reason_code_o,
  output logic [3:0]  type_code_o,
  output logic [19:0] entropy_q16_o,
  output logic [16:0] sampled_count_o
);

  logic [19:0] thresh_q;
  logic        push, full, pop, empty;
  qent_t       push_data, head;
  res_t        res;

  // threshold register, always writable
  assign cfg_ready_o = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      thresh_q <= 20'(ThreshReset);
    end else if (cfg_valid_i) begin
      thresh_q <= cfg_data_i;
    end
  end

  // front: byte intake, histogram, bin sweep
  cpf_front u_front (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .start          (start),
    .byte_value_i   (byte_value_i),
    .has_byte_i     (has_byte_i),
    .end_of_block_i (end_of_block_i),
    .busy           (busy),
    .push_o         (push),
    .push_data_o    (push_data),
    .full_i         (full)
  );

  cpf_fifo u_fifo (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (push),
    .data_i  (push_data),
    .full_o  (full),
    .pop_i   (pop),
    .empty_o (empty),
    .data_o  (head)
  );

  // back: entropy sum, divide, signature match, verdict
  cpf_back u_back (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .head_i   (head),
    .empty_i  (empty),
    .pop_o    (pop),
    .thresh_i (thresh_q),
    .res_o    (res)
  );

  assign done_o          = res.valid;
  assign store_raw_o     = res.store;
  assign reason_code_o   = res.reason;
  assign type_code_o     = res.kind;
  assign entropy_q16_o   = res.entropy;
  assign sampled_count_o = res.sampled;

endmodule

### hdl/cpf_checker.sv
module cpf_checker
  import cpf_pkg::*;
(
  input logic        clk_i,
  input logic        rst_ni,
  input logic        done_o,
  input logic        store_raw_o,
  input logic [1:0]  reason_code_o,
  input logic [3:0]  type_code_o,
  input logic [19:0] entropy_q16_o,
  input logic [16:0] sampled_count_o
);

  a_store_reason: assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_o |-> (store_raw_o == (reason_code_o != RSN_NONE)))
    else $error("store flag disagrees with reason");

  a_empty: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (done_o && reason_code_o == RSN_EMPTY) |->
      (entropy_q16_o == '0 && sampled_count_o == '0 && type_code_o == TYPE_NONE))
    else $error("empty block verdict carries data");

  a_magic: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (done_o && type_code_o != TYPE_NONE) |-> (reason_code_o == RSN_MAGIC))
    else $error("signature match without magic reason");

  a_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_o |-> (entropy_q16_o <= 20'(HMax) && sampled_count_o <= 17'(SampleMax)))
    else $error("entropy or sample count out of range");

endmodule

bind compressibility_prefilter_top cpf_checker u_cpf_checker (
  .clk_i           (clk_i),
  .rst_ni          (rst_ni),
  .done_o          (done_o),
  .store_raw_o     (store_raw_o),
  .reason_code_o   (reason_code_o),
  .type_code_o     (type_code_o),
  .entropy_q16_o   (entropy_q16_o),
  .sampled_count_o (sampled_count_o)
);

### tb/tb_compressibility_prefilter_top.sv
`timescale 1ns / 1ps

// Block-level test of the compressibility prefilter.
// Blocks of bytes go in through the start/busy command port; every closing
// transfer is predicted by a scoreboard that keeps its own histogram, lead
// bytes and count, and each verdict strobe is checked against it in order.
module tb_compressibility_prefilter_top;
  import cpf_pkg::*;

  typedef struct {
    logic        store;
    reason_e     reason;
    logic [3:0]  kind;
    logic [19:0] entropy;
    logic [16:0] sampled;
  } verdict_t;

  // Tracks the block in flight and queues the verdicts it must produce.
  class verdict_board;
    int unsigned       hist[256];
    logic [7:0]        lead[LeadLen];
    int unsigned       count;
    logic [19:0]       thresh;
    verdict_t          pending[$];
    int unsigned       errors;
    int unsigned       checked;

    function void clear_block();
      foreach (hist[i]) hist[i] = 0;
      foreach (lead[i]) lead[i] = 8'h00;
      count = 0;
    endfunction

    // log2(x) in Q.32, mantissa squared and truncated each step
    function longint unsigned log2_q32(longint unsigned x);
      int unsigned e;
      longint unsigned y, frac;
      e = 0;
      frac = 0;
      if (x == 0) return 0;
      while (e < 31 && (x >> (e + 1)) != 0) e++;
      y = x << (31 - e);
      for (int i = 0; i < 32; i++) begin
        y = (y * y) >> 31;
        frac = frac << 1;
        if (y >= 64'h1_0000_0000) begin
          frac = frac | 1;
          y = y >> 1;
        end
      end
      return (longint'(e) << 32) | frac;
    endfunction

    function logic [19:0] entropy_of(int unsigned m);
      longint unsigned sum, logm, q, c;
      sum = 0;
      if (m == 0) return 20'd0;
      for (int i = 0; i < 256; i++) begin
        c = hist[i];
        if (c != 0) sum += (c * log2_q32(c) + 32768) >> 16;
      end
      logm = (log2_q32(m) + 32768) >> 16;
      q = sum / m;
      if (q >= logm) return 20'd0;
      logm -= q;
      return (logm > HMax) ? 20'(HMax) : logm[19:0];
    endfunction

    function logic [3:0] signature();
      int unsigned n;
      n = count;
      if (n < 4) return TYPE_NONE;
      if (lead[0] == 8'hFF && lead[1] == 8'hD8 && lead[2] == 8'hFF) return TYPE_JPEG;
      if (n >= 8 && {lead[0], lead[1], lead[2], lead[3], lead[4], lead[5], lead[6], lead[7]}
          == 64'h89504E47_0D0A1A0A) return TYPE_PNG;
      if (n >= 6 && {lead[0], lead[1], lead[2], lead[3]} == "GIF8") return TYPE_GIF;
      if (n >= 12 && {lead[0], lead[1], lead[2], lead[3]} == "RIFF" &&
          {lead[8], lead[9], lead[10], lead[11]} == "WEBP") return TYPE_WEBP;
      if (n >= 12 && {lead[4], lead[5], lead[6], lead[7]} == "ftyp") return TYPE_MP4;
      if ({lead[0], lead[1]} == "PK" &&
          ({lead[2], lead[3]} == 16'h0304 || {lead[2], lead[3]} == 16'h0102 ||
           {lead[2], lead[3]} == 16'h0506 || {lead[2], lead[3]} == 16'h0708))
        return TYPE_ZIP;
      if (n >= 6 && {lead[0], lead[1], lead[2], lead[3], lead[4], lead[5]} == 48'h377ABCAF271C)
        return TYPE_7Z;
      if (lead[0] == 8'h1F && lead[1] == 8'h8B) return TYPE_GZIP;
      if ({lead[0], lead[1], lead[2], lead[3]} == 32'h28B52FFD) return TYPE_ZSTD;
      if (n >= 7 && {lead[0], lead[1], lead[2], lead[3], lead[4], lead[5]} == 48'h526172211A07)
        return TYPE_RAR;
      if ({lead[0], lead[1], lead[2]} == "BZh") return TYPE_BZIP2;
      if (n >= 6 && {lead[0], lead[1], lead[2], lead[3], lead[4], lead[5]} == 48'hFD377A585A00)
        return TYPE_XZ;
      if ({lead[0], lead[1], lead[2], lead[3]} == "OggS") return TYPE_OGG;
      if ({lead[0], lead[1], lead[2]} == "ID3" ||
          (lead[0] == 8'hFF && (lead[1] & 8'hE0) == 8'hE0)) return TYPE_MP3;
      if ({lead[0], lead[1], lead[2], lead[3]} == "wOF2") return TYPE_WOFF2;
      return TYPE_NONE;
    endfunction

    function void note_transfer(logic [7:0] b, logic has, logic eob);
      verdict_t v;
      int unsigned m;
      if (has) begin
        if (count < LeadLen) lead[count] = b;
        if (count < SampleMax) hist[b]++;
        if (count < CountMax) count++;
      end
      if (!eob) return;
      if (count == 0) begin
        v = '{1'b1, RSN_EMPTY, TYPE_NONE, 20'd0, 17'd0};
      end else begin
        m = (count < SampleMax) ? count : SampleMax;
        v.kind = signature();
        v.entropy = entropy_of(m);
        v.sampled = m[16:0];
        if (v.kind != TYPE_NONE) begin
          v.store = 1'b1;
          v.reason = RSN_MAGIC;
        end else if (v.entropy >= thresh) begin
          v.store = 1'b1;
          v.reason = RSN_ENTROPY;
        end else begin
          v.store = 1'b0;
          v.reason = RSN_NONE;
        end
      end
      pending.push_back(v);
      clear_block();
    endfunction

    function void check_verdict(logic store, logic [1:0] reason, logic [3:0] kind,
                                logic [19:0] entropy, logic [16:0] sampled);
      verdict_t v;
      checked++;
      if (pending.size() == 0) begin
        $error("verdict with none expected");
        errors++;
        return;
      end
      v = pending.pop_front();
      if (store !== v.store) begin
        $error("store_raw exp %0d got %0d", v.store, store); errors++;
      end
      if (reason !== v.reason) begin
        $error("reason_code exp %0d got %0d", v.reason, reason); errors++;
      end
      if (kind !== v.kind) begin
        $error("type_code exp %0d got %0d", v.kind, kind); errors++;
      end
      if (entropy !== v.entropy) begin
        $error("entropy_q16 exp %0d got %0d", v.entropy, entropy); errors++;
      end
      if (sampled !== v.sampled) begin
        $error("sampled_count exp %0d got %0d", v.sampled, sampled); errors++;
      end
    endfunction
  endclass

  localparam int unsigned StallLimit = 60000;

  logic        clk_i = 1'b0;
  logic        rst_ni = 1'b0;
  logic        start = 1'b0;
  logic        busy;
  logic [7:0]  byte_value_i = 8'h00;
  logic        has_byte_i = 1'b0;
  logic        end_of_block_i = 1'b0;
  logic        cfg_valid_i = 1'b0;
  logic        cfg_ready_o;
  logic [19:0] cfg_data_i = '0;
  logic        done_o;
  logic        store_raw_o;
  logic [1:0]  reason_code_o;
  logic [3:0]  type_code_o;
  logic [19:0] entropy_q16_o;
  logic [16:0] sampled_count_o;

  verdict_board board;
  int unsigned  idle_cycles;
  int unsigned  transfers;
  int unsigned  blocks;
  int unsigned  burst_left;
  bit           no_gaps;

  always #5 clk_i = ~clk_i;

  compressibility_prefilter_top dut (
    .clk_i, .rst_ni, .start, .busy,
    .byte_value_i, .has_byte_i, .end_of_block_i,
    .cfg_valid_i, .cfg_ready_o, .cfg_data_i,
    .done_o, .store_raw_o, .reason_code_o, .type_code_o,
    .entropy_q16_o, .sampled_count_o
  );

  // Result side: the strobe lasts one cycle and cannot be stalled, so check
  // every edge. The watchdog counts edges where nothing at all moved.
  always @(posedge clk_i) begin
    if (done_o) begin
      board.check_verdict(store_raw_o, reason_code_o, type_code_o,
                          entropy_q16_o, sampled_count_o);
    end
    if (done_o || (start && !busy) || (cfg_valid_i && cfg_ready_o)) begin
      idle_cycles <= 0;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
    if (idle_cycles >= StallLimit) begin
      $display("Testbench completed WITH ERRORS");
      $finish;
    end
  end

  // One byte transfer. The sender runs in bursts; between bursts start drops for a random
  // gap unless no_gaps is set, so that gaps land on every phase of the block.
  task automatic send_transfer(logic [7:0] b, logic has, logic eob);
    if (burst_left == 0) begin
      burst_left = $urandom_range(1, 24);
      if (!no_gaps) begin
        start <= 1'b0;
        repeat ($urandom_range(1, 6)) @(posedge clk_i);
      end
    end
    burst_left--;
    start          <= 1'b1;
    byte_value_i   <= b;
    has_byte_i     <= has;
    end_of_block_i <= eob;
    do @(posedge clk_i); while (busy);
    board.note_transfer(b, has, eob);
    transfers++;
    if (eob) blocks++;
  endtask

  // Waits out every expected verdict plus a margin for the tail of the sweep.
  task automatic drain();
    start <= 1'b0;
    burst_left = 0;
    while (board.pending.size() != 0) @(posedge clk_i);
    repeat (40) @(posedge clk_i);
  endtask

  task automatic write_threshold(logic [19:0] value);
    cfg_valid_i <= 1'b1;
    cfg_data_i  <= value;
    do @(posedge clk_i); while (!cfg_ready_o);
    cfg_valid_i <= 1'b0;
    board.thresh = value;
  endtask

  // Leading bytes of a signature, kind 1..15; n gets the prefix length.
  task automatic signature_prefix(int unsigned kind, output logic [7:0] p[LeadLen],
                                  output int unsigned n);
    logic [15:0] zip_tail[4];
    zip_tail = '{16'h0304, 16'h0102, 16'h0506, 16'h0708};
    foreach (p[i]) p[i] = 8'($urandom_range(0, 255));
    case (kind)
      TYPE_JPEG:  begin {p[0], p[1], p[2]} = 24'hFFD8FF; n = 3; end
      TYPE_PNG:   begin
        {p[0], p[1], p[2], p[3], p[4], p[5], p[6], p[7]} = 64'h89504E47_0D0A1A0A; n = 8;
      end
      TYPE_GIF:   begin {p[0], p[1], p[2], p[3]} = "GIF8"; n = 4; end
      TYPE_WEBP:  begin
        {p[0], p[1], p[2], p[3]} = "RIFF"; {p[8], p[9], p[10], p[11]} = "WEBP"; n = 12;
      end
      TYPE_MP4:   begin {p[4], p[5], p[6], p[7]} = "ftyp"; n = 8; end
      TYPE_ZIP:   begin
        {p[0], p[1]} = "PK"; {p[2], p[3]} = zip_tail[$urandom_range(0, 3)]; n = 4;
      end
      TYPE_7Z:    begin {p[0], p[1], p[2], p[3], p[4], p[5]} = 48'h377ABCAF271C; n = 6; end
      TYPE_GZIP:  begin {p[0], p[1]} = 16'h1F8B; n = 2; end
      TYPE_ZSTD:  begin {p[0], p[1], p[2], p[3]} = 32'h28B52FFD; n = 4; end
      TYPE_RAR:   begin {p[0], p[1], p[2], p[3], p[4], p[5]} = 48'h526172211A07; n = 6; end
      TYPE_BZIP2: begin {p[0], p[1], p[2]} = "BZh"; n = 3; end
      TYPE_XZ:    begin {p[0], p[1], p[2], p[3], p[4], p[5]} = 48'hFD377A585A00; n = 6; end
      TYPE_OGG:   begin {p[0], p[1], p[2], p[3]} = "OggS"; n = 4; end
      TYPE_MP3:   begin
        if ($urandom_range(0, 1)) {p[0], p[1], p[2]} = "ID3";
        else {p[0], p[1]} = {8'hFF, 3'b111, 5'($urandom_range(0, 31))};
        n = 3;
      end
      default:    begin {p[0], p[1], p[2], p[3]} = "wOF2"; n = 4; end
    endcase
  endtask

  // One block: sometimes a signature head, random tail, lengths mostly
  // around the signature length conditions, now and then a few hundred.
  task automatic random_block();
    logic [7:0]  head[LeadLen];
    int unsigned n, len, alphabet;
    logic        bare_end;
    foreach (head[i]) head[i] = 8'($urandom_range(0, 255));
    n = 0;
    if ($urandom_range(0, 9) < 6) signature_prefix($urandom_range(1, 15), head, n);
    case ($urandom_range(0, 9))
      0:       len = $urandom_range(0, 3);
      1, 2:    len = $urandom_range(100, 400);
      default: len = $urandom_range(n > 0 ? n - 1 : 1, 14);
    endcase
    alphabet = ($urandom_range(0, 1)) ? 255 : $urandom_range(0, 7);
    bare_end = ($urandom_range(0, 3) == 0) || (len == 0);
    for (int i = 0; i < len; i++) begin
      if ($urandom_range(0, 15) == 0)
        send_transfer(8'($urandom_range(0, 255)), 1'b0, 1'b0);
      send_transfer(i < LeadLen && i < n ? head[i] : 8'($urandom_range(0, alphabet)),
                    1'b1, !bare_end && (i == len - 1));
    end
    if (bare_end) send_transfer(8'($urandom_range(0, 255)), 1'b0, 1'b1);
  endtask

  initial begin
    logic [19:0] settings[5];
    board = new();
    board.clear_block();
    board.thresh = 20'(ThreshReset);
    idle_cycles = 0;
    transfers = 0;
    blocks = 0;
    burst_left = 0;
    no_gaps = 0;

    repeat (3) @(posedge clk_i);
    rst_ni <= 1'b1;

    // Directed: empty block, idle noise, short jpeg head, bare end after
    // bytes, extreme byte values, a block of identical bytes.
    send_transfer(8'hFF, 1'b0, 1'b1);
    send_transfer(8'hFF, 1'b0, 1'b0);
    send_transfer(8'hFF, 1'b1, 1'b0);
    send_transfer(8'hD8, 1'b1, 1'b0);
    send_transfer(8'hFF, 1'b1, 1'b1);
    send_transfer(8'h00, 1'b1, 1'b0);
    send_transfer(8'hFF, 1'b1, 1'b0);
    send_transfer(8'h00, 1'b0, 1'b1);
    send_transfer(8'h00, 1'b1, 1'b1);
    send_transfer(8'hFF, 1'b1, 1'b1);
    for (int i = 0; i < 8; i++) send_transfer(8'h5A, 1'b1, i == 7);
    drain();

    settings = '{20'd0, 20'd524288, 20'hFFFFF, 20'($urandom_range(200000, 400000)),
                 20'(ThreshReset)};
    foreach (settings[s]) begin
      write_threshold(settings[s]);
      no_gaps = (s == 2);
      while (transfers < 20 + (s + 1) * 200) random_block();
      drain();
    end

    $display("Covered %0d transfers in %0d blocks, %0d verdicts checked, five thresholds.",
             transfers, blocks, board.checked);
    if (board.errors == 0 && board.pending.size() == 0) begin
      $display("Testbench completed without errors");
    end else begin
      $display("Testbench completed WITH ERRORS");
    end
    $finish;
  end

endmodule
